// File: src/extent_map_translator_assert.svh
// Assertion helpers for the extent map translator.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef EXTENT_MAP_TRANSLATOR_ASSERT_SVH
`define EXTENT_MAP_TRANSLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EMT_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("extent_map_translator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("extent_map_translator: next-cycle check failed");

`endif

// File: src/emt_pkg.sv
`default_nettype none

package emt_pkg;

  // Request codes carried in the func field.
  localparam logic [1:0] FUNC_CLEAR     = 2'd0;
  localparam logic [1:0] FUNC_APPEND    = 2'd1;
  localparam logic [1:0] FUNC_TRANSLATE = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

  // Configuration register indexes and their reset values.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE_LOG         = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_BLOCKS           = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_BLOCK_LOG        = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PARTITION_FIRST_SECTOR = 8'd3;

  localparam logic [4:0]  RST_BLOCK_SIZE_LOG         = 5'd12;
  localparam logic [31:0] RST_GROUP_BLOCKS           = 32'd1;
  localparam logic [4:0]  RST_GROUP_BLOCK_LOG        = 5'd1;
  localparam logic [31:0] RST_PARTITION_FIRST_SECTOR = 32'd0;

  // Input beat.
  typedef struct packed {
    logic [1:0]  func;
    logic [53:0] extent_file_block;
    logic [51:0] extent_disk_block;
    logic [20:0] extent_length;
    logic [62:0] byte_offset;
    logic [39:0] bytes_wanted;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic        mapped;
    logic [63:0] disk_address;
    logic [39:0] chunk_bytes;
  } out_item_t;

  // Configuration registers.
  typedef struct packed {
    logic [4:0]  block_size_log;
    logic [31:0] group_blocks;
    logic [4:0]  group_block_log;
    logic [31:0] partition_first_sector;
  } cfg_t;

  // One table entry; the end block is kept instead of the length.
  typedef struct packed {
    logic [53:0] file_start;
    logic [54:0] file_end;
    logic [51:0] disk_start;
  } extent_t;

  // Request from the scan to the address unit.
  typedef struct packed {
    logic        start;
    extent_t     entry;
    logic [62:0] blk;
    logic [30:0] boff;
    logic [39:0] want;
  } calc_req_t;

  // Answer from the address unit.
  typedef struct packed {
    logic        done;
    logic [63:0] disk_address;
    logic [39:0] chunk_bytes;
  } calc_res_t;

  // Top-level sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLE,
    ST_CALC,
    ST_DONE
  } state_e;

  // Address unit steps.
  typedef enum logic [2:0] {
    CALC_IDLE,
    CALC_FSB,
    CALC_MUL_LO,
    CALC_MUL_HI,
    CALC_SUM,
    CALC_ADDR,
    CALC_DONE
  } calc_e;

endpackage

`default_nettype wire

// File: src/emt_extent_mem.sv
`default_nettype none

module emt_extent_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [IdxW-1:0]   wr_addr_i,
  input  wire emt_pkg::extent_t  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [IdxW-1:0]   rd_addr_i,
  output emt_pkg::extent_t       rd_data_o
);

  emt_pkg::extent_t ext_mem_q [Depth];
  emt_pkg::extent_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ext_mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port: the entry shows at rd_data_o in the cycle after rd_en_i.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ext_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: src/emt_addr_calc.sv
`default_nettype none

module emt_addr_calc (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire emt_pkg::cfg_t      cfg_i,
  input  wire emt_pkg::calc_req_t req_i,
  output emt_pkg::calc_res_t      res_o
);

  emt_pkg::calc_e state_q, state_d;

  logic [20:0] within_q;
  logic [20:0] left_blk_q;
  logic [51:0] disk_q;
  logic [52:0] fsb_q;
  logic [51:0] left_q;
  logic [39:0] chunk_q;
  logic [63:0] mul_q;
  logic [63:0] phys_q;
  logic [63:0] addr_q;

  logic [62:0] blk_minus_start;
  logic [62:0] end_minus_blk;
  logic [52:0] agno;
  logic [52:0] agbno;
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [51:0] left_shift;
  logic [51:0] left_bytes;
  logic [63:0] byte_part;
  logic [63:0] base;

  // Position of the block inside the hit extent; both fit in 21 bits.
  assign blk_minus_start = req_i.blk - {9'b0, req_i.entry.file_start};
  assign end_minus_blk   = {8'b0, req_i.entry.file_end} - req_i.blk;

  // Split the filesystem block into group number and block within the group.
  assign agno  = fsb_q >> cfg_i.group_block_log;
  assign agbno = fsb_q & ((53'd1 << cfg_i.group_block_log) - 53'd1);

  // One shared 32 by 32 multiplier: low half of the group number, then the high half.
  assign mul_a = (state_q == emt_pkg::CALC_MUL_LO) ? agno[31:0] : {11'b0, agno[52:32]};
  assign mul_p = 64'(mul_a) * 64'(cfg_i.group_blocks);

  // Bytes left to the end of the extent.
  assign left_shift = {31'b0, left_blk_q} << cfg_i.block_size_log;
  assign left_bytes = left_shift - {21'b0, req_i.boff};

  // The low bits of the shifted block are zero, so the offset is merged by OR.
  assign byte_part = (phys_q << cfg_i.block_size_log) | {33'b0, req_i.boff};
  assign base      = {23'b0, cfg_i.partition_first_sector, 9'b0};

  // Step register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= emt_pkg::CALC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step sequence.
  always_comb begin
    state_d = state_q;
    case (state_q)
      emt_pkg::CALC_IDLE:   if (req_i.start) state_d = emt_pkg::CALC_FSB;
      emt_pkg::CALC_FSB:    state_d = emt_pkg::CALC_MUL_LO;
      emt_pkg::CALC_MUL_LO: state_d = emt_pkg::CALC_MUL_HI;
      emt_pkg::CALC_MUL_HI: state_d = emt_pkg::CALC_SUM;
      emt_pkg::CALC_SUM:    state_d = emt_pkg::CALC_ADDR;
      emt_pkg::CALC_ADDR:   state_d = emt_pkg::CALC_DONE;
      emt_pkg::CALC_DONE:   state_d = emt_pkg::CALC_IDLE;
      default:              state_d = emt_pkg::CALC_IDLE;
    endcase
  end

  // Datapath, one piece of arithmetic per step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      emt_pkg::CALC_IDLE: begin
        if (req_i.start) begin
          within_q   <= blk_minus_start[20:0];
          left_blk_q <= end_minus_blk[20:0];
          disk_q     <= req_i.entry.disk_start;
        end
      end
      emt_pkg::CALC_FSB: begin
        fsb_q  <= {1'b0, disk_q} + {32'b0, within_q};
        left_q <= left_bytes;
      end
      emt_pkg::CALC_MUL_LO: begin
        mul_q   <= mul_p;
        chunk_q <= ({12'b0, req_i.want} < left_q) ? req_i.want : left_q[39:0];
      end
      emt_pkg::CALC_MUL_HI: begin
        phys_q <= mul_q + {11'b0, agbno};
        mul_q  <= mul_p;
      end
      emt_pkg::CALC_SUM: begin
        phys_q <= phys_q + {mul_q[31:0], 32'b0};
      end
      emt_pkg::CALC_ADDR: begin
        addr_q <= base + byte_part;
      end
      default: begin
      end
    endcase
  end

  assign res_o.done         = (state_q == emt_pkg::CALC_DONE);
  assign res_o.disk_address = addr_q;
  assign res_o.chunk_bytes  = chunk_q;

endmodule

`default_nettype wire

// File: src/extent_map_translator.sv
// Extent map translator. The block holds a table of up to EXTENT_SLOTS file extents in a
// memory with one write port and one registered read port and answers one request at a
// time: clear, append or translate; an unused code gives a plain OK beat. A clear or an
// append passes through ST_DONE into the output register. A translate reads the table in
// append order, one entry per cycle through the memory's read port, and goes to ST_HOLE
// when no entry covers the block; on the first hit the address unit works out the disk
// address in steps FSB, MUL_LO, MUL_HI, SUM and ADDR on one shared 32 by 32 multiplier.
// A new request is taken while the previous result beat still waits at the output. The
// table needs no clearing pass after reset.
`default_nettype none

module extent_map_translator #(
  parameter int unsigned EXTENT_SLOTS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire emt_pkg::in_item_t                  in_item_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output emt_pkg::out_item_t                      out_item_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [emt_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [31:0]                        cfg_data_i
);

  `include "extent_map_translator_assert.svh"

  localparam int unsigned IDX_W = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(EXTENT_SLOTS + 1);

  emt_pkg::state_e    state_q, state_d;
  emt_pkg::cfg_t      cfg_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   chk_q, chk_d;
  logic [62:0]        blk_q;
  logic [30:0]        boff_q;
  logic [39:0]        want_q;
  emt_pkg::out_item_t res_q, res_d;
  emt_pkg::out_item_t out_q;
  logic               out_valid_q, out_valid_d;

  logic               in_acc;
  logic               out_load;
  logic               full;
  logic               zero_len;
  logic               wr_en;
  emt_pkg::extent_t   wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  emt_pkg::extent_t   rd_data;
  logic               hit;
  logic               last;
  logic [31:0]        hole_left;
  logic [39:0]        hole_chunk;
  emt_pkg::calc_req_t calc_req;
  emt_pkg::calc_res_t calc_res;

  assign in_ready_o  = (state_q == emt_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Append decode.
  assign full     = (count_q == CNT_W'(EXTENT_SLOTS));
  assign zero_len = (in_item_i.extent_length == 21'd0);
  assign wr_en    = in_acc && (in_item_i.func == emt_pkg::FUNC_APPEND) && !zero_len && !full;
  assign wr_data.file_start = in_item_i.extent_file_block;
  assign wr_data.file_end   = {1'b0, in_item_i.extent_file_block} +
                              {34'b0, in_item_i.extent_length};
  assign wr_data.disk_start = in_item_i.extent_disk_block;

  // Scan reads: entry 0 on acceptance, then the entry after the one being checked.
  assign rd_en   = (in_acc && (in_item_i.func == emt_pkg::FUNC_TRANSLATE)) ||
                   (state_q == emt_pkg::ST_SCAN);
  assign rd_addr = (state_q == emt_pkg::ST_SCAN) ? chk_q + 1'b1 : '0;

  emt_extent_mem #(
    .Depth (EXTENT_SLOTS),
    .IdxW  (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Coverage check of the entry read last cycle.
  assign hit  = (blk_q >= {9'b0, rd_data.file_start}) && (blk_q < {8'b0, rd_data.file_end});
  assign last = ((CNT_W'(chk_q) + CNT_W'(1)) == count_q);

  // A hole runs to the end of its block.
  assign hole_left  = (32'd1 << cfg_q.block_size_log) - {1'b0, boff_q};
  assign hole_chunk = (want_q < {8'b0, hole_left}) ? want_q : {8'b0, hole_left};

  assign calc_req.start = (state_q == emt_pkg::ST_SCAN) && hit;
  assign calc_req.entry = rd_data;
  assign calc_req.blk   = blk_q;
  assign calc_req.boff  = boff_q;
  assign calc_req.want  = want_q;

  emt_addr_calc u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (calc_req),
    .res_o  (calc_res)
  );

  // Sequencer: next state, table count and pending result.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    chk_d    = chk_q;
    res_d    = res_q;
    out_load = 1'b0;
    case (state_q)
      emt_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          state_d = emt_pkg::ST_DONE;
          case (in_item_i.func)
            emt_pkg::FUNC_CLEAR: count_d = '0;
            emt_pkg::FUNC_APPEND: begin
              if (zero_len) begin
                res_d.status = emt_pkg::STATUS_ZERO_LEN;
              end else if (full) begin
                res_d.status = emt_pkg::STATUS_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            emt_pkg::FUNC_TRANSLATE: begin
              chk_d   = '0;
              state_d = (count_q == '0) ? emt_pkg::ST_HOLE : emt_pkg::ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      emt_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = emt_pkg::ST_CALC;
        end else if (last) begin
          state_d = emt_pkg::ST_HOLE;
        end else begin
          chk_d = chk_q + 1'b1;
        end
      end
      emt_pkg::ST_HOLE: begin
        res_d.status       = emt_pkg::STATUS_OK;
        res_d.mapped       = 1'b0;
        res_d.disk_address = '0;
        res_d.chunk_bytes  = hole_chunk;
        state_d            = emt_pkg::ST_DONE;
      end
      emt_pkg::ST_CALC: begin
        if (calc_res.done) begin
          res_d.status       = emt_pkg::STATUS_OK;
          res_d.mapped       = 1'b1;
          res_d.disk_address = calc_res.disk_address;
          res_d.chunk_bytes  = calc_res.chunk_bytes;
          state_d            = emt_pkg::ST_DONE;
        end
      end
      emt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = emt_pkg::ST_IDLE;
        end
      end
      default: state_d = emt_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= emt_pkg::ST_IDLE;
      count_q     <= '0;
      chk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size_log         <= emt_pkg::RST_BLOCK_SIZE_LOG;
      cfg_q.group_blocks           <= emt_pkg::RST_GROUP_BLOCKS;
      cfg_q.group_block_log        <= emt_pkg::RST_GROUP_BLOCK_LOG;
      cfg_q.partition_first_sector <= emt_pkg::RST_PARTITION_FIRST_SECTOR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        emt_pkg::REG_BLOCK_SIZE_LOG:         cfg_q.block_size_log <= cfg_data_i[4:0];
        emt_pkg::REG_GROUP_BLOCKS:           cfg_q.group_blocks <= cfg_data_i;
        emt_pkg::REG_GROUP_BLOCK_LOG:        cfg_q.group_block_log <= cfg_data_i[4:0];
        emt_pkg::REG_PARTITION_FIRST_SECTOR: cfg_q.partition_first_sector <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Payload registers: request operands, pending result and output beat.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_q  <= in_item_i.byte_offset >> cfg_q.block_size_log;
      boff_q <= in_item_i.byte_offset[30:0] & ((31'd1 << cfg_q.block_size_log) - 31'd1);
      want_q <= in_item_i.bytes_wanted;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks.
  `EMT_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CNT_W'(EXTENT_SLOTS))
  `EMT_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != emt_pkg::ST_IDLE)
  `EMT_ASSERT_IMPLIES(a_calc_done_in_calc, calc_res.done, state_q == emt_pkg::ST_CALC)
  `EMT_ASSERT_NEXT(a_done_loads_output, out_load, out_valid_o && (state_q == emt_pkg::ST_IDLE))

endmodule

`default_nettype wire

// File: test/emt_result_checker.sv
module emt_result_checker
  import emt_pkg::*;
#(
  parameter int unsigned EXTENT_SLOTS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  in_item_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  out_item_t              out_item_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the extent table and the registers.
  logic [53:0] file_start_q [EXTENT_SLOTS];
  logic [51:0] disk_start_q [EXTENT_SLOTS];
  logic [20:0] length_q     [EXTENT_SLOTS];
  int unsigned extent_count_q;
  cfg_t        regs_q;

  // Result beats predicted but not yet seen at the output.
  out_item_t   awaited_beats [$];
  out_item_t   oldest;
  int unsigned fails = 0;

  // Turns a filesystem block into a disk byte address, modulo 2^64.
  function automatic logic [63:0] disk_byte_of(logic [63:0] fsb);
    logic [63:0] group_no;
    logic [63:0] group_off;
    logic [63:0] phys;
    group_no  = fsb >> regs_q.group_block_log;
    group_off = fsb & ((64'd1 << regs_q.group_block_log) - 64'd1);
    phys      = group_no * {32'd0, regs_q.group_blocks} + group_off;
    return {32'd0, regs_q.partition_first_sector} * 64'd512
           + (phys << regs_q.block_size_log);
  endfunction

  // Applies one request to the shadow table and gives the beat it must produce.
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t   beat;
    logic [63:0] blk;
    logic [63:0] boff;
    logic [63:0] want;
    logic [63:0] first;
    logic [63:0] span;
    logic [63:0] into_ext;
    logic [63:0] left;
    bit          hit;
    beat = '0;
    hit  = 1'b0;
    case (req.func)
      FUNC_CLEAR: begin
        extent_count_q = 0;
      end
      FUNC_APPEND: begin
        // A zero length is reported before a full table.
        if (req.extent_length == '0) begin
          beat.status = STATUS_ZERO_LEN;
        end else if (extent_count_q >= EXTENT_SLOTS) begin
          beat.status = STATUS_FULL;
        end else begin
          file_start_q[extent_count_q] = req.extent_file_block;
          disk_start_q[extent_count_q] = req.extent_disk_block;
          length_q[extent_count_q]     = req.extent_length;
          extent_count_q++;
        end
      end
      FUNC_TRANSLATE: begin
        blk  = {1'b0, req.byte_offset} >> regs_q.block_size_log;
        boff = {1'b0, req.byte_offset} & ((64'd1 << regs_q.block_size_log) - 64'd1);
        want = {24'd0, req.bytes_wanted};
        // The first covering entry in append order wins.
        for (int i = 0; i < extent_count_q; i++) begin
          first = {10'd0, file_start_q[i]};
          span  = {43'd0, length_q[i]};
          if (!hit && blk >= first && blk < first + span) begin
            hit               = 1'b1;
            into_ext          = blk - first;
            left              = ((span - into_ext) << regs_q.block_size_log) - boff;
            beat.mapped       = 1'b1;
            beat.disk_address = disk_byte_of({12'd0, disk_start_q[i]} + into_ext) + boff;
            beat.chunk_bytes  = (want < left) ? want[39:0] : left[39:0];
          end
        end
        // A hole runs to the end of the block.
        if (!hit) begin
          left             = (64'd1 << regs_q.block_size_log) - boff;
          beat.chunk_bytes = (want < left) ? want[39:0] : left[39:0];
        end
      end
      default: begin
      end
    endcase
    return beat;
  endfunction

  task automatic check_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
      fails++;
    end
  endtask

  // Watch all three channels; the output is handled before a new request is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_count_q = 0;
      regs_q.block_size_log         = RST_BLOCK_SIZE_LOG;
      regs_q.group_blocks           = RST_GROUP_BLOCKS;
      regs_q.group_block_log        = RST_GROUP_BLOCK_LOG;
      regs_q.partition_first_sector = RST_PARTITION_FIRST_SECTOR;
      awaited_beats.delete();
      awaited_count_o  <= 0;
      mismatch_count_o <= fails;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_beats.size() == 0) begin
          $display("%0t: result beat %h with nothing awaited", $time, out_item_i);
          fails++;
        end else begin
          oldest = awaited_beats.pop_front();
          check_field("status", 64'(oldest.status), 64'(out_item_i.status));
          check_field("mapped", 64'(oldest.mapped), 64'(out_item_i.mapped));
          check_field("disk_address", oldest.disk_address, out_item_i.disk_address);
          check_field("chunk_bytes", 64'(oldest.chunk_bytes), 64'(out_item_i.chunk_bytes));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BLOCK_SIZE_LOG:         regs_q.block_size_log         = cfg_data_i[4:0];
          REG_GROUP_BLOCKS:           regs_q.group_blocks           = cfg_data_i;
          REG_GROUP_BLOCK_LOG:        regs_q.group_block_log        = cfg_data_i[4:0];
          REG_PARTITION_FIRST_SECTOR: regs_q.partition_first_sector = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        awaited_beats.push_back(serve_request(in_item_i));
      end
      awaited_count_o  <= awaited_beats.size();
      mismatch_count_o <= fails;
    end
  end

endmodule

// File: test/extent_map_translator_tb.sv
module extent_map_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import emt_pkg::*;

  localparam int unsigned EXTENT_SLOTS = 64;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam int          LONG_HOLD    = 400;
  localparam int          QUIET_LIMIT  = 20000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 150;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  in_item_t               in_item_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  out_item_t              out_item_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [31:0]            cfg_data_i;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int          quiet_cycles = 0;
  cfg_t        cur_setting;

  extent_map_translator #(
    .EXTENT_SLOTS(EXTENT_SLOTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  emt_result_checker #(
    .EXTENT_SLOTS(EXTENT_SLOTS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_item_i       (out_item_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random stalls, and one long hold-off when asked for.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Ends the run if no channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL extent_map_translator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Every field random; the fields a request does not use stay as noise.
  function automatic in_item_t noise_req();
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t append_req(logic [53:0] file_blk, logic [51:0] disk_blk,
                                          logic [20:0] len);
    in_item_t req;
    req                   = noise_req();
    req.func              = FUNC_APPEND;
    req.extent_file_block = file_blk;
    req.extent_disk_block = disk_blk;
    req.extent_length     = len;
    return req;
  endfunction

  function automatic in_item_t translate_req(logic [62:0] offset, logic [39:0] want);
    in_item_t req;
    req              = noise_req();
    req.func         = FUNC_TRANSLATE;
    req.byte_offset  = offset;
    req.bytes_wanted = want;
    return req;
  endfunction

  // Mostly appends and translates aimed at a window of file blocks just above base,
  // so that lookups hit, miss and overlap; the rest is clears and noise.
  function automatic in_item_t make_request(logic [63:0] base);
    in_item_t    req;
    int unsigned roll;
    int unsigned pick;
    logic [63:0] blk;
    logic [4:0]  bsl;
    bsl  = cur_setting.block_size_log;
    roll = $urandom_range(99);
    pick = $urandom_range(19);
    req  = noise_req();
    if (roll < 1) begin
      req.func = FUNC_CLEAR;
    end else if (roll < 41) begin
      req.func              = FUNC_APPEND;
      req.extent_file_block = 54'(base + $urandom_range(0, 255));
      if (pick == 0) begin
        req.extent_length = '0;
      end else if (pick > 1) begin
        req.extent_length = 21'($urandom_range(1, 32));
      end
    end else if (roll < 93) begin
      req.func        = FUNC_TRANSLATE;
      blk             = base + $urandom_range(0, 300);
      req.byte_offset = 63'((blk << bsl) | (rand64() & ((64'd1 << bsl) - 64'd1)));
      if (pick == 0) begin
        req.bytes_wanted = '0;
      end else if (pick < 10) begin
        req.bytes_wanted = 40'($urandom_range(1, 1 << 17));
      end
    end else if (roll < 96) begin
      req.func = FUNC_UNUSED;
    end else begin
      req.func = 2'($urandom_range(FUNC_CLEAR, FUNC_TRANSLATE));
    end
    return req;
  endfunction

  // Offers one request beat, after a random idle stretch, and waits for acceptance.
  task automatic push_request(in_item_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drops the request valid and waits until every predicted beat has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_count != 0);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Registers are only rewritten once the block has gone quiet.
  task automatic program_regs(cfg_t setting);
    wait_drained();
    put_reg(REG_BLOCK_SIZE_LOG, {27'd0, setting.block_size_log});
    put_reg(REG_GROUP_BLOCKS, setting.group_blocks);
    put_reg(REG_GROUP_BLOCK_LOG, {27'd0, setting.group_block_log});
    put_reg(REG_PARTITION_FIRST_SECTOR, setting.partition_first_sector);
    cfg_valid_i <= 1'b0;
    cur_setting = setting;
  endtask

  initial begin
    cfg_t        setting;
    in_item_t    req;
    logic [63:0] base;
    int          window;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cur_setting.block_size_log         = RST_BLOCK_SIZE_LOG;
    cur_setting.group_blocks           = RST_GROUP_BLOCKS;
    cur_setting.group_block_log        = RST_GROUP_BLOCK_LOG;
    cur_setting.partition_first_sector = RST_PARTITION_FIRST_SECTOR;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset settings (4 KiB blocks).
    push_request(translate_req('0, '1));
    push_request(translate_req('1, '1));
    push_request(translate_req(63'd5000, '0));
    push_request(append_req(54'd7, 52'd9, '0));
    req      = '1;
    req.func = FUNC_UNUSED;
    push_request(req);
    push_request(append_req(54'd10, 52'd100, 21'd5));
    push_request(append_req(54'd12, 52'd200, 21'd3));
    push_request(translate_req(63'(12 * 4096 + 7), '1));
    push_request(translate_req(63'(14 * 4096 + 100), 40'd10));
    push_request(translate_req(63'(14 * 4096 + 100), '1));
    push_request(translate_req(63'(15 * 4096), '1));
    push_request(append_req('1, '1, '1));
    push_request(append_req(54'h7_FFFF_FFE0_0000, '1, '1));
    push_request(translate_req('1, '1));
    push_request(append_req('0, '0, 21'd1));
    push_request(translate_req('0, 40'd1));
    push_request(req);
    req.func = FUNC_CLEAR;
    push_request(req);
    push_request(translate_req(63'(12 * 4096), '1));

    // Fill the table, then append to it when full, with and without a length.
    for (int i = 0; i < EXTENT_SLOTS; i++) begin
      push_request(append_req(54'(4 * i), 52'(rand64()), 21'd4));
    end
    push_request(append_req(54'd900, 52'd5, 21'd7));
    push_request(append_req(54'd900, 52'd5, '0));
    push_request(translate_req(63'(255 * 4096 + 9), '1));

    // Hold the result side off while long lookups keep arriving.
    hold_off_req = 1'b1;
    repeat (24) begin
      push_request(translate_req(63'(($urandom_range(0, 300) << 12) + $urandom_range(0, 4095)),
                                 40'($urandom)));
    end
    push_request(req);

    // Random phases across register settings and idling patterns.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 5)
        0: setting = '{block_size_log: 5'd12, group_blocks: 32'd1,
                       group_block_log: 5'd1, partition_first_sector: 32'd0};
        1: setting = '{block_size_log: 5'd9, group_blocks: 32'hFFFF_FFFF,
                       group_block_log: 5'd31, partition_first_sector: 32'hFFFF_FFFF};
        2: setting = '{block_size_log: 5'd16, group_blocks: 32'd1000,
                       group_block_log: 5'd10, partition_first_sector: 32'd2048};
        3: setting = '{block_size_log: 5'd31, group_blocks: 32'd3,
                       group_block_log: 5'd0, partition_first_sector: 32'd5};
        default: setting = '{block_size_log: 5'd0, group_blocks: 32'h8000_0001,
                             group_block_log: 5'd20, partition_first_sector: 32'd123};
      endcase
      program_regs(setting);
      case (ph % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 56;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 56;
        end
        default: begin
          sender_idle_pct    = 26;
          receiver_stall_pct = 26;
        end
      endcase
      // Keep the block window small enough that shifted offsets stay in range.
      window = (61 - int'(setting.block_size_log) < 53) ? 61 - int'(setting.block_size_log) : 53;
      base   = rand64() & ((64'd1 << window) - 64'd1);
      repeat (PHASE_ITEMS) push_request(make_request(base));
    end

    // Let the last beats drain, then allow a quiet margin for stray beats.
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("PASS extent_map_translator");
    end else begin
      $display("FAIL extent_map_translator");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/emt_pkg.sv
src/emt_extent_mem.sv
src/emt_addr_calc.sv
src/extent_map_translator.sv
test/emt_result_checker.sv
test/extent_map_translator_tb.sv
